// ===== rtl/fbc_pkg.sv =====
// Shared constants, types and plane tables for the frustum box culling block.
`default_nettype none
package fbc_pkg;

    localparam int COEF_BITS    = 24;
    localparam int COORD_BITS   = 24;
    localparam int COORD_FRAC   = COORD_BITS - 16;
    localparam int VEC_COUNT    = 4;
    localparam int ELEM_COUNT   = 4;
    localparam int AXIS_COUNT   = 3;
    localparam int PLANE_COUNT  = 6;
    localparam int PLANE_BITS   = 3;
    localparam int VEC_IDX_BITS = 2;

    localparam int COEF_W = COEF_BITS + 1;
    localparam int PROD_W = COEF_W + COORD_BITS;
    localparam int SUM_W  = PROD_W + 2;

    localparam int ELEM_LSB    = VEC_IDX_BITS;
    localparam int BOX_LSB     = ELEM_LSB + ELEM_COUNT * COEF_BITS;
    localparam int S_TDATA_RAW = BOX_LSB + 2 * AXIS_COUNT * COORD_BITS;
    localparam int S_TDATA_W   = ((S_TDATA_RAW + 7) / 8) * 8;
    localparam int M_TDATA_W   = 8;

    localparam logic [PLANE_BITS-1:0] PLANE_LAST = PLANE_BITS'(PLANE_COUNT - 1);
    localparam logic                  OP_LOAD    = 1'b0;
    localparam logic                  OP_TEST    = 1'b1;

    typedef struct packed {
        logic                  ld_vec;
        logic                  start;
        logic                  issue;
        logic                  last;
        logic [PLANE_BITS-1:0] plane;
        logic                  ld_out;
    } fbc_cmd_t;

    typedef struct packed {
        logic fin;
    } fbc_sts_t;

    // left, right, top, bottom, near, far
    function automatic logic [VEC_IDX_BITS-1:0] plane_vec(input logic [PLANE_BITS-1:0] p);
        logic [VEC_IDX_BITS-1:0] v;
        v = VEC_IDX_BITS'(p >> 1);
        return v;
    endfunction

    function automatic logic plane_add(input logic [PLANE_BITS-1:0] p);
        logic a;
        case (p)
            3'd0:    a = 1'b1;
            3'd3:    a = 1'b1;
            3'd4:    a = 1'b1;
            default: a = 1'b0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/fbc_ctrl.sv =====
// Sequencer: handshakes, plane counter and result-register control.
`default_nettype none
module fbc_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic              s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output fbc_pkg::fbc_cmd_t      cmd,
    input  wire fbc_pkg::fbc_sts_t sts
);
    import fbc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } fbc_state_t;

    fbc_state_t            state_reg, state_next;
    logic [PLANE_BITS-1:0] plane_reg, plane_next;
    logic                  mvalid_reg, mvalid_next;
    logic                  s_fire;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = mvalid_reg;

    always_comb begin
        state_next = state_reg;
        plane_next = plane_reg;
        cmd        = '0;
        cmd.plane  = plane_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_axis_tuser == OP_TEST) begin
                        cmd.start  = 1'b1;
                        plane_next = '0;
                        state_next = ST_RUN;
                    end else begin
                        cmd.ld_vec = 1'b1;
                    end
                end
            end
            ST_RUN: begin
                cmd.issue = 1'b1;
                cmd.last  = (plane_reg == PLANE_LAST);
                if (plane_reg == PLANE_LAST) begin
                    state_next = ST_DRAIN;
                end else begin
                    plane_next = plane_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (sts.fin) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!mvalid_reg || m_axis_tready) begin
                    cmd.ld_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        mvalid_next = mvalid_reg;
        if (cmd.ld_out) begin
            mvalid_next = 1'b1;
        end else if (m_axis_tready) begin
            mvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            plane_reg  <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            plane_reg  <= plane_next;
            mvalid_reg <= mvalid_next;
        end
    end

    a_fin_in_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.fin |-> state_reg == ST_DRAIN)
        else $error("pipeline finished outside drain");

    a_plane_range: assert property (@(posedge aclk) disable iff (!aresetn)
        plane_reg <= PLANE_LAST)
        else $error("plane counter out of range");

    a_test_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_axis_tuser == OP_TEST) |=> state_reg == ST_RUN)
        else $error("test word did not start plane sweep");

    a_run_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && plane_reg == PLANE_LAST) |=> state_reg == ST_DRAIN)
        else $error("plane sweep overran");

endmodule
`default_nettype wire

// ===== rtl/fbc_datapath.sv =====
// Matrix store, box registers and the shared four-term plane distance pipeline.
`default_nettype none
module fbc_datapath (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [fbc_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire fbc_pkg::fbc_cmd_t              cmd,
    output fbc_pkg::fbc_sts_t                   sts,
    output logic                                box_inside
);
    import fbc_pkg::*;

    logic signed [COEF_BITS-1:0]  mat_reg [VEC_COUNT][ELEM_COUNT];
    logic signed [COORD_BITS-1:0] lo_reg [AXIS_COUNT];
    logic signed [COORD_BITS-1:0] hi_reg [AXIS_COUNT];

    logic signed [COEF_W-1:0]     base_w [ELEM_COUNT];
    logic signed [COEF_W-1:0]     oth_w  [ELEM_COUNT];
    logic signed [COEF_W-1:0]     c1_next [ELEM_COUNT];
    logic signed [COORD_BITS-1:0] k1_next [AXIS_COUNT];
    logic [VEC_IDX_BITS-1:0]      vsel;
    logic                         addp;

    logic signed [COEF_W-1:0]     c1_reg [ELEM_COUNT];
    logic signed [COORD_BITS-1:0] k1_reg [AXIS_COUNT];
    logic                         v1_reg, l1_reg;

    logic signed [PROD_W-1:0]     p2_reg [AXIS_COUNT];
    logic signed [SUM_W-1:0]      d2_reg;
    logic                         v2_reg, l2_reg;

    logic signed [SUM_W-1:0]      plane_dist;
    logic                         inside_reg, inside_next;
    logic                         out_reg;

    assign vsel = plane_vec(cmd.plane);
    assign addp = plane_add(cmd.plane);

    always_comb begin
        for (int e = 0; e < ELEM_COUNT; e++) begin
            base_w[e]  = COEF_W'(mat_reg[VEC_COUNT-1][e]);
            oth_w[e]   = COEF_W'(mat_reg[vsel][e]);
            c1_next[e] = addp ? (base_w[e] + oth_w[e]) : (base_w[e] - oth_w[e]);
        end
        for (int a = 0; a < AXIS_COUNT; a++) begin
            k1_next[a] = (c1_next[a] > 0) ? hi_reg[a] : lo_reg[a];
        end
    end

    // box accepted as inside unless some plane distance is negative
    assign plane_dist = SUM_W'(p2_reg[0]) + SUM_W'(p2_reg[1]) + SUM_W'(p2_reg[2]) + d2_reg;
    assign sts.fin = v2_reg && l2_reg;

    always_comb begin
        inside_next = inside_reg;
        if (cmd.start) begin
            inside_next = 1'b1;
        end else if (v2_reg && plane_dist[SUM_W-1]) begin
            inside_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int v = 0; v < VEC_COUNT; v++) begin
                for (int e = 0; e < ELEM_COUNT; e++) begin
                    mat_reg[v][e] <= '0;
                end
            end
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            l1_reg     <= 1'b0;
            l2_reg     <= 1'b0;
            inside_reg <= 1'b1;
        end else begin
            if (cmd.ld_vec) begin
                for (int e = 0; e < ELEM_COUNT; e++) begin
                    mat_reg[s_tdata[VEC_IDX_BITS-1:0]][e] <=
                        s_tdata[ELEM_LSB + e*COEF_BITS +: COEF_BITS];
                end
            end
            v1_reg     <= cmd.issue;
            l1_reg     <= cmd.issue && cmd.last;
            v2_reg     <= v1_reg;
            l2_reg     <= l1_reg;
            inside_reg <= inside_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            for (int a = 0; a < AXIS_COUNT; a++) begin
                lo_reg[a] <= s_tdata[BOX_LSB + a*COORD_BITS +: COORD_BITS];
                hi_reg[a] <= s_tdata[BOX_LSB + (AXIS_COUNT + a)*COORD_BITS +: COORD_BITS];
            end
        end
        for (int e = 0; e < ELEM_COUNT; e++) begin
            c1_reg[e] <= c1_next[e];
        end
        for (int a = 0; a < AXIS_COUNT; a++) begin
            k1_reg[a] <= k1_next[a];
            p2_reg[a] <= PROD_W'(c1_reg[a]) * PROD_W'(k1_reg[a]);
        end
        d2_reg <= SUM_W'(c1_reg[ELEM_COUNT-1]) <<< COORD_FRAC;
        if (cmd.ld_out) begin
            out_reg <= inside_reg;
        end
    end

    assign box_inside = out_reg;

endmodule
`default_nettype wire

// ===== rtl/frustum_box_culling.sv =====
// Top level: view frustum culling of axis-aligned boxes against a loaded matrix.
//
//  channel  dir  ports                        word
//  s_axis   in   tvalid tready tuser tdata    tuser=opcode, tdata=vector or box
//  m_axis   out  tvalid tready tdata          box_inside, one per box test
//
//  A load word is written into the matrix and the next word is accepted right after it.
//  A box test sweeps the six planes through one shared dot product unit, one
//  plane a cycle, then drains the pipeline and loads the output register;
//  the next word is accepted in the cycle the result turns valid.
//  The result sits in an output register; a new word is taken while it waits,
//  but a finished test holds the input off until that register is free.
//  Reset clears the matrix to zero and empties the pipeline.
`default_nettype none
module frustum_box_culling (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // opcode
    input  wire logic                          s_axis_tuser,
    // vec_index, vec_elem_0..3, box_min_x/y/z, box_max_x/y/z, zero pad
    input  wire logic [fbc_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // box_inside, zero pad
    output logic [fbc_pkg::M_TDATA_W-1:0]      m_axis_tdata
);
    import fbc_pkg::*;

    fbc_cmd_t cmd;
    fbc_sts_t sts;
    logic     box_inside;

    fbc_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cmd           (cmd),
        .sts           (sts)
    );

    fbc_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tdata    (s_axis_tdata),
        .cmd        (cmd),
        .sts        (sts),
        .box_inside (box_inside)
    );

    assign m_axis_tdata = {{(M_TDATA_W-1){1'b0}}, box_inside};

endmodule
`default_nettype wire
